// ----- src/tsrb_pkg.sv -----
`timescale 1ns / 1ps
package tsrb_pkg;

   localparam int TS_W   = 64;
   localparam int LEN_W  = 13;
   localparam int IDX_W  = 12;
   localparam int PART_W = 16;

   localparam logic [1:0] OP_WRITE     = 2'd0;
   localparam logic [1:0] OP_READ      = 2'd1;
   localparam logic [1:0] OP_SET_FIRST = 2'd2;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_WRITE_PAST = 3'd1;
   localparam logic [2:0] ST_OVERWRITE  = 3'd2;
   localparam logic [2:0] ST_READ_PAST  = 3'd3;
   localparam logic [2:0] ST_READ_AHEAD = 3'd4;
   localparam logic [2:0] ST_BAD_FIRST  = 3'd5;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_WRITE,
      KIND_READ
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [2:0] status;
   } cmd_type;

endpackage

// ----- src/timestamped_sample_ring_buffer_unit.sv -----
`timescale 1ns / 1ps
// An accepted item whose slot is already known is held in the front hold register, then written
// into the queue, and its result comes from the back end's response register.
// Throughput: 1 item per cycle while items keep the timestamp of the item before them; an item
// that touches the store with a new timestamp first waits for its slot remainder.
// Reset: synchronous; afterwards busy stays high while the store is zeroed one word per cycle.
// Results are never held off by the receiver.
module timestamped_sample_ring_buffer_unit #(
   parameter int BUFFER_SAMPLES = 4096,
   parameter int CHANNEL_COUNT  = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_opcode,
   input  logic [63:0]                req_block_timestamp,
   input  logic [12:0]                req_block_length,
   input  logic [11:0]                req_sample_index,
   input  logic signed [15:0]         req_ch0_i,
   input  logic signed [15:0]         req_ch0_q,
   input  logic signed [15:0]         req_ch1_i,
   input  logic signed [15:0]         req_ch1_q,
   output logic                       rsp_valid,
   output logic [2:0]                 rsp_status,
   output logic                       rsp_sample_valid,
   output logic signed [15:0]         rsp_out_ch0_i,
   output logic signed [15:0]         rsp_out_ch0_q,
   output logic signed [15:0]         rsp_out_ch1_i,
   output logic signed [15:0]         rsp_out_ch1_q
);

   localparam int SLOT_W  = $clog2(BUFFER_SAMPLES);
   localparam int DATA_W  = 2 * tsrb_pkg::PART_W * CHANNEL_COUNT;
   localparam int CMD_W   = $bits(tsrb_pkg::cmd_type);
   localparam int ENTRY_W = CMD_W + SLOT_W + DATA_W;
   localparam int Q_DEPTH = 4;

   logic                    accept;
   logic                    front_busy;
   logic                    clearing;
   logic [DATA_W-1:0]       req_data;
   logic                    push;
   tsrb_pkg::cmd_type       push_cmd;
   logic [SLOT_W-1:0]       push_slot;
   logic [DATA_W-1:0]       push_data;
   logic                    queue_full;
   logic                    head_valid;
   logic [ENTRY_W-1:0]      head_data;
   logic                    pop;
   tsrb_pkg::cmd_type       head_cmd;
   logic [DATA_W-1:0]       rsp_data;

   assign busy   = clearing || front_busy;
   assign accept = start && !busy;

   generate
      if (CHANNEL_COUNT > 1) begin : g_two_ch
         assign req_data      = {req_ch1_q, req_ch1_i, req_ch0_q, req_ch0_i};
         assign rsp_out_ch1_i = rsp_data[47:32];
         assign rsp_out_ch1_q = rsp_data[63:48];
      end else begin : g_one_ch
         assign req_data      = {req_ch0_q, req_ch0_i};
         assign rsp_out_ch1_i = '0;
         assign rsp_out_ch1_q = '0;
      end
   endgenerate

   assign rsp_out_ch0_i = rsp_data[15:0];
   assign rsp_out_ch0_q = rsp_data[31:16];

   tsrb_front #(
      .BUFFER_SAMPLES(BUFFER_SAMPLES),
      .SLOT_W        (SLOT_W),
      .DATA_W        (DATA_W)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .opcode         (req_opcode),
      .block_timestamp(req_block_timestamp),
      .block_length   (req_block_length),
      .sample_index   (req_sample_index),
      .sample_data    (req_data),
      .queue_full     (queue_full),
      .busy           (front_busy),
      .push           (push),
      .push_cmd       (push_cmd),
      .push_slot      (push_slot),
      .push_data      (push_data)
   );

   tsrb_queue #(
      .WIDTH(ENTRY_W),
      .DEPTH(Q_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_cmd, push_slot, push_data}),
      .pop       (pop),
      .full      (queue_full),
      .head_valid(head_valid),
      .head_data (head_data)
   );

   assign head_cmd = tsrb_pkg::cmd_type'(head_data[ENTRY_W-1 -: CMD_W]);

   tsrb_back #(
      .BUFFER_SAMPLES(BUFFER_SAMPLES),
      .SLOT_W        (SLOT_W),
      .DATA_W        (DATA_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (head_valid),
      .cmd             (head_cmd),
      .cmd_slot        (head_data[DATA_W +: SLOT_W]),
      .cmd_data        (head_data[DATA_W-1:0]),
      .cmd_pop         (pop),
      .clearing        (clearing),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_sample_valid(rsp_sample_valid),
      .rsp_data        (rsp_data)
   );

`ifndef SYNTHESIS
   a_no_result_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !rsp_valid && !head_valid)
      else $error("result or queued item while the store is being cleared");
   a_busy_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> busy)
      else $error("item could be accepted while the store is being cleared");
   a_sample_only_when_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sample_valid |-> rsp_status == tsrb_pkg::ST_OK)
      else $error("read sample delivered with an error status");
`endif

endmodule

// ----- src/tsrb_ram.sv -----
`timescale 1ns / 1ps
module tsrb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/tsrb_slot.sv -----
`timescale 1ns / 1ps
module tsrb_slot #(
   parameter int BUFFER_SAMPLES = 4096,
   parameter int SLOT_W         = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req,
   input  logic [tsrb_pkg::TS_W-1:0]  ts,
   input  logic [tsrb_pkg::IDX_W-1:0] idx,
   output logic                       ready,
   output logic [SLOT_W-1:0]          slot
);

   localparam int SUM_W  = ((SLOT_W > tsrb_pkg::IDX_W) ? SLOT_W : tsrb_pkg::IDX_W) + 1;
   localparam int FOLD_W = 27;
   localparam int PROD_W = 2 * FOLD_W;
   localparam int QUOT_W = 11;
   localparam int DIFF_W = 28;
   localparam logic [SUM_W-1:0]  N_SUM     = SUM_W'(BUFFER_SAMPLES);
   localparam logic [DIFF_W-1:0] N_DIFF    = DIFF_W'(BUFFER_SAMPLES);
   localparam logic [FOLD_W-1:0] RECIP     = FOLD_W'((64'd1 << FOLD_W) / 64'(BUFFER_SAMPLES));
   localparam logic              LAST_STEP = 1'b1;

   logic                      cache_valid_ff;
   logic [tsrb_pkg::TS_W-1:0] cache_ts_ff;
   logic [SLOT_W-1:0]         cache_base_ff;
   logic                      run_ff;
   logic                      cnt_ff;
   logic [FOLD_W-1:0]         fold_ff;
   logic [QUOT_W-1:0]         quot_ff;

   logic              hit;
   logic              start;
   logic [7:0][23:0]  part;
   logic [FOLD_W-1:0] fold_in;
   logic [PROD_W-1:0] quot_prod;
   logic [QUOT_W-1:0] quot_in;
   logic [DIFF_W-1:0] quot_mul;
   logic [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0] rem_in;
   logic [SUM_W-1:0]  sum;
   logic [SUM_W-1:0]  sum_wrap;

   assign hit   = cache_valid_ff && (cache_ts_ff == ts);
   assign ready = req && hit;
   assign start = req && !hit && !run_ff;

   // Each timestamp byte is weighted by its power of 256 modulo the buffer size.
   for (genvar k = 0; k < 8; k++) begin : g_fold
      localparam logic [15:0] WEIGHT = 16'((64'd1 << (8 * k)) % 64'(BUFFER_SAMPLES));
      assign part[k] = 24'(ts[8*k +: 8]) * 24'(WEIGHT);
   end

   always_comb begin
      fold_in = '0;
      for (int k = 0; k < 8; k++) begin
         fold_in = fold_in + FOLD_W'(part[k]);
      end
   end

   // The reciprocal quotient is at most one short, so one compare and subtract ends it.
   assign quot_prod = PROD_W'(fold_ff) * PROD_W'(RECIP);
   assign quot_in   = quot_prod[FOLD_W +: QUOT_W];
   assign quot_mul  = DIFF_W'(quot_ff) * N_DIFF;
   assign diff      = DIFF_W'(fold_ff) - quot_mul;
   assign rem_in    = (diff >= N_DIFF) ? (diff - N_DIFF) : diff;

   assign sum      = SUM_W'(cache_base_ff) + SUM_W'(idx);
   assign sum_wrap = (sum >= N_SUM) ? (sum - N_SUM) : sum;
   assign slot     = sum_wrap[SLOT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cache_valid_ff <= 1'b0;
         run_ff         <= 1'b0;
         cnt_ff         <= 1'b0;
      end else if (start) begin
         cache_valid_ff <= 1'b0;
         run_ff         <= 1'b1;
         cnt_ff         <= 1'b0;
      end else if (run_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            run_ff         <= 1'b0;
            cache_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cache_ts_ff <= ts;
         fold_ff     <= fold_in;
      end else if (run_ff) begin
         if (cnt_ff == LAST_STEP) begin
            cache_base_ff <= rem_in[SLOT_W-1:0];
         end else begin
            quot_ff <= quot_in;
         end
      end
   end

`ifndef SYNTHESIS
   a_done_fills_cache: assert property (@(posedge clock) disable iff (reset)
      run_ff && (cnt_ff == LAST_STEP) |=> cache_valid_ff && !run_ff)
      else $error("slot cache not filled at end of remainder pass");
`endif

endmodule

// ----- src/tsrb_queue.sv -----
`timescale 1ns / 1ps
module tsrb_queue #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff;
   logic [AW-1:0]    rd_ptr_ff;
   logic [CW-1:0]    count_ff;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("item pushed into a full queue");
`endif

endmodule

// ----- src/tsrb_front.sv -----
`timescale 1ns / 1ps
module tsrb_front #(
   parameter int BUFFER_SAMPLES = 4096,
   parameter int SLOT_W         = 12,
   parameter int DATA_W         = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [1:0]                 opcode,
   input  logic [tsrb_pkg::TS_W-1:0]  block_timestamp,
   input  logic [tsrb_pkg::LEN_W-1:0] block_length,
   input  logic [tsrb_pkg::IDX_W-1:0] sample_index,
   input  logic [DATA_W-1:0]          sample_data,
   input  logic                       queue_full,
   output logic                       busy,
   output logic                       push,
   output tsrb_pkg::cmd_type          push_cmd,
   output logic [SLOT_W-1:0]          push_slot,
   output logic [DATA_W-1:0]          push_data
);

   localparam logic [16:0] N_EXT = 17'(BUFFER_SAMPLES);
   localparam logic [tsrb_pkg::TS_W-1:0] N_TS = tsrb_pkg::TS_W'(BUFFER_SAMPLES);

   logic                       hold_valid_ff;
   logic [1:0]                 hold_op_ff;
   logic [tsrb_pkg::TS_W-1:0]  hold_ts_ff;
   logic [tsrb_pkg::LEN_W-1:0] hold_len_ff;
   logic [tsrb_pkg::IDX_W-1:0] hold_idx_ff;
   logic [DATA_W-1:0]          hold_data_ff;

   logic [tsrb_pkg::TS_W-1:0]  lw_ff;
   logic [tsrb_pkg::TS_W-1:0]  lr_ff;
   logic                       wr_acc_ff;
   logic                       rd_acc_ff;

   logic [tsrb_pkg::TS_W-1:0]  lw_in;
   logic [tsrb_pkg::TS_W-1:0]  lr_in;
   logic                       wr_acc_in;
   logic                       rd_acc_in;
   logic                       hold_valid_in;

   logic [tsrb_pkg::LEN_W-1:0] len_eff;
   logic                       in_range;
   logic                       first;
   logic                       last;
   logic [tsrb_pkg::TS_W-1:0]  end_ts;
   logic [tsrb_pkg::TS_W-1:0]  span;
   logic                       is_wr;
   logic                       is_rd;
   logic                       is_set;
   logic                       wr_past;
   logic                       wr_over;
   logic                       rd_past;
   logic                       rd_ahead;
   logic                       wr_go;
   logic                       rd_go;
   logic                       need_slot;
   logic                       slot_ready;
   logic [SLOT_W-1:0]          slot;
   logic                       complete;
   logic [2:0]                 status;

   tsrb_slot #(
      .BUFFER_SAMPLES(BUFFER_SAMPLES),
      .SLOT_W        (SLOT_W)
   ) u_slot (
      .clock(clock),
      .reset(reset),
      .req  (hold_valid_ff && need_slot),
      .ts   (hold_ts_ff),
      .idx  (hold_idx_ff),
      .ready(slot_ready),
      .slot (slot)
   );

   always_comb begin
      if (hold_len_ff == '0) begin
         len_eff = tsrb_pkg::LEN_W'(1);
      end else if (17'(hold_len_ff) > N_EXT) begin
         len_eff = N_EXT[tsrb_pkg::LEN_W-1:0];
      end else begin
         len_eff = hold_len_ff;
      end
   end

   assign in_range = tsrb_pkg::LEN_W'(hold_idx_ff) < len_eff;
   assign first    = (hold_idx_ff == '0);
   assign last     = tsrb_pkg::LEN_W'(hold_idx_ff) == (len_eff - tsrb_pkg::LEN_W'(1));
   assign end_ts   = hold_ts_ff + tsrb_pkg::TS_W'(len_eff) - tsrb_pkg::TS_W'(1);
   assign span     = hold_ts_ff + tsrb_pkg::TS_W'(len_eff) - lr_ff;

   assign is_wr  = (hold_op_ff == tsrb_pkg::OP_WRITE) && in_range;
   assign is_rd  = (hold_op_ff == tsrb_pkg::OP_READ) && in_range;
   assign is_set = (hold_op_ff == tsrb_pkg::OP_SET_FIRST);

   assign wr_past  = !(hold_ts_ff > lw_ff);
   assign wr_over  = span > N_TS;
   assign rd_past  = (hold_ts_ff != '0) && !(hold_ts_ff > lr_ff);
   assign rd_ahead = lw_ff < end_ts;

   assign wr_go = first ? (!wr_past && !wr_over) : wr_acc_ff;
   assign rd_go = first ? (!rd_past && !rd_ahead) : rd_acc_ff;

   assign need_slot = (is_wr && wr_go) || (is_rd && rd_go);
   assign complete  = hold_valid_ff && !queue_full && (!need_slot || slot_ready);
   assign busy      = hold_valid_ff && !complete;

   always_comb begin
      status    = tsrb_pkg::ST_OK;
      lw_in     = lw_ff;
      lr_in     = lr_ff;
      wr_acc_in = wr_acc_ff;
      rd_acc_in = rd_acc_ff;
      if (is_wr) begin
         if (first && wr_past) begin
            status = tsrb_pkg::ST_WRITE_PAST;
         end else if (first && wr_over) begin
            status = tsrb_pkg::ST_OVERWRITE;
         end
         wr_acc_in = last ? 1'b0 : wr_go;
         if (wr_go && last) begin
            lw_in = end_ts;
         end
      end else if (is_rd) begin
         if (first && rd_past) begin
            status = tsrb_pkg::ST_READ_PAST;
         end else if (first && rd_ahead) begin
            status = tsrb_pkg::ST_READ_AHEAD;
         end
         rd_acc_in = last ? 1'b0 : rd_go;
         if (rd_go && last) begin
            lr_in = end_ts;
         end
      end else if (is_set) begin
         if (lw_ff != '0) begin
            status = tsrb_pkg::ST_BAD_FIRST;
         end else if (hold_ts_ff != '0) begin
            if (lr_ff != '0) begin
               status = tsrb_pkg::ST_BAD_FIRST;
            end else begin
               lr_in = hold_ts_ff - tsrb_pkg::TS_W'(1);
            end
         end
      end
   end

   always_comb begin
      push_cmd.status = status;
      if (is_wr && wr_go) begin
         push_cmd.kind = tsrb_pkg::KIND_WRITE;
      end else if (is_rd && rd_go) begin
         push_cmd.kind = tsrb_pkg::KIND_READ;
      end else begin
         push_cmd.kind = tsrb_pkg::KIND_NONE;
      end
   end

   assign push      = complete;
   assign push_slot = slot;
   assign push_data = hold_data_ff;

   assign hold_valid_in = accept || (hold_valid_ff && !complete);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         lw_ff         <= '0;
         lr_ff         <= '0;
         wr_acc_ff     <= 1'b0;
         rd_acc_ff     <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         if (complete) begin
            lw_ff     <= lw_in;
            lr_ff     <= lr_in;
            wr_acc_ff <= wr_acc_in;
            rd_acc_ff <= rd_acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_op_ff   <= opcode;
         hold_ts_ff   <= block_timestamp;
         hold_len_ff  <= block_length;
         hold_idx_ff  <= sample_index;
         hold_data_ff <= sample_data;
      end
   end

endmodule

// ----- src/tsrb_back.sv -----
`timescale 1ns / 1ps
module tsrb_back #(
   parameter int BUFFER_SAMPLES = 4096,
   parameter int SLOT_W         = 12,
   parameter int DATA_W         = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  tsrb_pkg::cmd_type cmd,
   input  logic [SLOT_W-1:0] cmd_slot,
   input  logic [DATA_W-1:0] cmd_data,
   output logic              cmd_pop,
   output logic              clearing,
   output logic              rsp_valid,
   output logic [2:0]        rsp_status,
   output logic              rsp_sample_valid,
   output logic [DATA_W-1:0] rsp_data
);

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(BUFFER_SAMPLES - 1);

   logic              clear_ff;
   logic [SLOT_W-1:0] clr_addr_ff;
   logic              rsp_valid_ff;
   logic [2:0]        rsp_status_ff;
   logic              rsp_read_ff;

   logic              is_write;
   logic              is_read;
   logic              ram_we;
   logic [SLOT_W-1:0] ram_waddr;
   logic [DATA_W-1:0] ram_wdata;
   logic [DATA_W-1:0] ram_rdata;

   always_comb begin
      is_write = 1'b0;
      is_read  = 1'b0;
      case (cmd.kind)
         tsrb_pkg::KIND_WRITE: begin
            is_write = 1'b1;
         end
         tsrb_pkg::KIND_READ: begin
            is_read = 1'b1;
         end
         default: begin
            is_write = 1'b0;
            is_read  = 1'b0;
         end
      endcase
   end

   assign cmd_pop   = cmd_valid && !clear_ff;
   assign ram_we    = clear_ff || (cmd_pop && is_write);
   assign ram_waddr = clear_ff ? clr_addr_ff : cmd_slot;
   assign ram_wdata = clear_ff ? '0 : cmd_data;

   tsrb_ram #(
      .WIDTH(DATA_W),
      .DEPTH(BUFFER_SAMPLES)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(cmd_slot),
      .rd_data(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_read_ff  <= 1'b0;
      end else begin
         if (clear_ff) begin
            clr_addr_ff <= clr_addr_ff + SLOT_W'(1);
            if (clr_addr_ff == LAST_SLOT) begin
               clear_ff <= 1'b0;
            end
         end
         rsp_valid_ff <= cmd_pop;
         rsp_read_ff  <= cmd_pop && is_read;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         rsp_status_ff <= cmd.status;
      end
   end

   assign clearing         = clear_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_sample_valid = rsp_read_ff;
   assign rsp_data         = rsp_read_ff ? ram_rdata : '0;

endmodule

// ----- sim/timestamped_sample_ring_buffer_unit_tb.sv -----
`timescale 1ns / 1ps
module timestamped_sample_ring_buffer_unit_tb;

   localparam int DEPTH      = 4096;
   localparam int CHANNELS   = 2;
   localparam int ITEMS      = 1950;
   localparam int QUIET_TAIL = 300;
   localparam int PAUSE_STEP = 400;
   localparam int SETTLE     = 100;
   localparam int LIMIT      = 1000000;
   localparam int MAX_REPORT = 10;

   localparam logic [1:0]  OP_UNUSED = 2'd3;
   localparam logic [63:0] WRAP_TS   = 64'hFFFF_FFFF_FFFF_FFFE;

   typedef struct packed {
      logic [2:0]  status;
      logic        sample_valid;
      logic [15:0] ch0_i;
      logic [15:0] ch0_q;
      logic [15:0] ch1_i;
      logic [15:0] ch1_q;
   } rb_result_type;

   class ring_buffer_scoreboard;
      logic [63:0]   slot_word [DEPTH];
      logic [63:0]   last_wr;
      logic [63:0]   last_rd;
      bit            wr_open;
      bit            rd_open;
      rb_result_type pending_q [$];
      int            mismatches;

      function new();
         foreach (slot_word[i]) slot_word[i] = '0;
         last_wr    = '0;
         last_rd    = '0;
         wr_open    = 1'b0;
         rd_open    = 1'b0;
         mismatches = 0;
      endfunction

      function void note_item(input logic [1:0] op, input logic [63:0] ts,
                              input logic [12:0] len_raw, input logic [11:0] idx,
                              input logic [63:0] word);
         logic [63:0]   len;
         logic [63:0]   pos;
         logic [63:0]   data;
         rb_result_type r;
         r = '0;
         if (len_raw == 13'd0) len = 64'd1;
         else if (len_raw > DEPTH) len = 64'(DEPTH);
         else len = 64'(len_raw);
         pos = 64'(idx);
         if (CHANNELS < 2) word[63:32] = '0;
         if (op == tsrb_pkg::OP_WRITE && pos < len) begin
            if (pos == 64'd0) begin
               wr_open = 1'b0;
               if (!(ts > last_wr)) r.status = tsrb_pkg::ST_WRITE_PAST;
               else if ((ts + len) - last_rd > 64'(DEPTH))
                  r.status = tsrb_pkg::ST_OVERWRITE;
               else wr_open = 1'b1;
            end
            if (wr_open) begin
               slot_word[(ts + pos) % 64'(DEPTH)] = word;
               if (pos == len - 64'd1) last_wr = ts + len - 64'd1;
            end
            if (pos == len - 64'd1) wr_open = 1'b0;
         end else if (op == tsrb_pkg::OP_READ && pos < len) begin
            if (pos == 64'd0) begin
               rd_open = 1'b0;
               if (ts != 64'd0 && !(ts > last_rd)) r.status = tsrb_pkg::ST_READ_PAST;
               else if (last_wr < ts + len - 64'd1) r.status = tsrb_pkg::ST_READ_AHEAD;
               else rd_open = 1'b1;
            end
            if (rd_open) begin
               data = slot_word[(ts + pos) % 64'(DEPTH)];
               r.sample_valid = 1'b1;
               r.ch0_i = data[15:0];
               r.ch0_q = data[31:16];
               r.ch1_i = data[47:32];
               r.ch1_q = data[63:48];
               if (pos == len - 64'd1) last_rd = ts + len - 64'd1;
            end
            if (pos == len - 64'd1) rd_open = 1'b0;
         end else if (op == tsrb_pkg::OP_SET_FIRST) begin
            if (last_wr != 64'd0) r.status = tsrb_pkg::ST_BAD_FIRST;
            else if (ts != 64'd0) begin
               if (last_rd != 64'd0) r.status = tsrb_pkg::ST_BAD_FIRST;
               else last_rd = ts - 64'd1;
            end
         end
         pending_q.push_back(r);
      endfunction

      function void check_result(input logic [2:0] status, input logic sample_valid,
                                 input logic [15:0] c0i, input logic [15:0] c0q,
                                 input logic [15:0] c1i, input logic [15:0] c1q);
         rb_result_type got;
         rb_result_type want;
         got = {status, sample_valid, c0i, c0q, c1i, c1q};
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORT)
               $display("unexpected result: status=%0d valid=%0b ch=%h %h %h %h",
                        got.status, got.sample_valid, got.ch0_i, got.ch0_q,
                        got.ch1_i, got.ch1_q);
         end else begin
            want = pending_q.pop_front();
            if (got.status !== want.status || got.sample_valid !== want.sample_valid ||
                got.ch0_i !== want.ch0_i || got.ch0_q !== want.ch0_q ||
                got.ch1_i !== want.ch1_i || got.ch1_q !== want.ch1_q) begin
               mismatches++;
               if (mismatches <= MAX_REPORT)
                  $display("mismatch: exp status=%0d valid=%0b ch=%h %h %h %h,",
                           want.status, want.sample_valid, want.ch0_i, want.ch0_q,
                           want.ch1_i, want.ch1_q,
                           " got status=%0d valid=%0b ch=%h %h %h %h",
                           got.status, got.sample_valid,
                           got.ch0_i, got.ch0_q, got.ch1_i, got.ch1_q);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_opcode = '0;
   logic [63:0] req_block_timestamp = '0;
   logic [12:0] req_block_length = '0;
   logic [11:0] req_sample_index = '0;
   logic signed [15:0] req_ch0_i = '0;
   logic signed [15:0] req_ch0_q = '0;
   logic signed [15:0] req_ch1_i = '0;
   logic signed [15:0] req_ch1_q = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic        rsp_sample_valid;
   logic signed [15:0] rsp_out_ch0_i;
   logic signed [15:0] rsp_out_ch0_q;
   logic signed [15:0] rsp_out_ch1_i;
   logic signed [15:0] rsp_out_ch1_q;

   ring_buffer_scoreboard sb = new();
   int items_sent = 0;
   bit idle_on = 1'b1;

   timestamped_sample_ring_buffer_unit #(
      .BUFFER_SAMPLES(DEPTH),
      .CHANNEL_COUNT(CHANNELS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_block_timestamp(req_block_timestamp),
      .req_block_length(req_block_length),
      .req_sample_index(req_sample_index),
      .req_ch0_i(req_ch0_i),
      .req_ch0_q(req_ch0_q),
      .req_ch1_i(req_ch1_i),
      .req_ch1_q(req_ch1_q),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_sample_valid(rsp_sample_valid),
      .rsp_out_ch0_i(rsp_out_ch0_i),
      .rsp_out_ch0_q(rsp_out_ch0_q),
      .rsp_out_ch1_i(rsp_out_ch1_i),
      .rsp_out_ch1_q(rsp_out_ch1_q)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result(rsp_status, rsp_sample_valid, rsp_out_ch0_i, rsp_out_ch0_q,
                         rsp_out_ch1_i, rsp_out_ch1_q);
   end

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic int pick_length(input longint avail);
      int r;
      int want;
      r = $urandom_range(0, 99);
      if (r < 75) want = $urandom_range(1, 8);
      else if (r < 92) want = $urandom_range(9, 40);
      else if (r < 97) want = DEPTH;
      else want = $urandom_range(1024, DEPTH);
      if (avail >= 1 && $urandom_range(0, 9) != 0 && want > avail) want = int'(avail);
      return want;
   endfunction

   function automatic logic [12:0] encode_length(input int want);
      if (want == DEPTH && $urandom_range(0, 1) == 0)
         return 13'($urandom_range(DEPTH + 1, 8191));
      if (want == 1 && $urandom_range(0, 7) == 0) return 13'd0;
      return 13'(want);
   endfunction

   task automatic send_item(input logic [1:0] op, input logic [63:0] ts,
                            input logic [12:0] len_raw, input logic [11:0] idx,
                            input logic [63:0] word);
      int eff;
      if (len_raw == 13'd0) eff = 1;
      else if (len_raw > DEPTH) eff = DEPTH;
      else eff = int'(len_raw);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      start = 1'b1;
      req_opcode = op;
      req_block_timestamp = ts;
      req_block_length = len_raw;
      req_sample_index = idx;
      req_ch0_i = word[15:0];
      req_ch0_q = word[31:16];
      req_ch1_i = word[47:32];
      req_ch1_q = word[63:48];
      do @(posedge clock); while (busy);
      sb.note_item(op, ts, len_raw, idx, word);
      if (op != OP_UNUSED && int'(idx) < eff) items_sent++;
      @(negedge clock);
   endtask

   task automatic send_block(input logic [1:0] op, input logic [63:0] ts,
                             input logic [12:0] len_raw, input bit broken);
      int eff;
      int pos;
      if (len_raw == 13'd0) eff = 1;
      else if (len_raw > DEPTH) eff = DEPTH;
      else eff = int'(len_raw);
      if (eff <= 24) begin
         for (pos = 0; pos < eff; pos++)
            if (!(broken && pos == eff - 1)) send_item(op, ts, len_raw, 12'(pos), rand_word());
      end else begin
         send_item(op, ts, len_raw, 12'd0, rand_word());
         pos = $urandom_range(1, eff / 4);
         while (pos < eff - 1) begin
            send_item(op, ts, len_raw, 12'(pos), rand_word());
            pos += $urandom_range(1, eff / 4);
         end
         if (!broken) send_item(op, ts, len_raw, 12'(eff - 1), rand_word());
      end
   endtask

   task automatic random_write();
      logic [63:0] ts;
      longint room;
      ts = sb.last_wr + 64'd1;
      if ($urandom_range(0, 4) == 0) ts += 64'($urandom_range(1, 8));
      if ($urandom_range(0, 19) == 0) ts = sb.last_wr;
      room = longint'(sb.last_rd + 64'(DEPTH) - ts);
      send_block(tsrb_pkg::OP_WRITE, ts, encode_length(pick_length(room)),
                 $urandom_range(0, 19) == 0);
   endtask

   task automatic random_read();
      logic [63:0] ts;
      longint avail;
      int r;
      r = $urandom_range(0, 39);
      ts = sb.last_rd + 64'd1;
      if (r < 2 && sb.last_rd != 64'd0) ts = sb.last_rd;
      else if (r == 2) ts = '0;
      avail = longint'(sb.last_wr - ts) + 1;
      send_block(tsrb_pkg::OP_READ, ts, encode_length(pick_length(avail)),
                 $urandom_range(0, 19) == 0);
   endtask

   task automatic random_noise();
      logic [63:0] ts;
      if ($urandom_range(0, 1) == 0) ts = rand_word();
      else ts = sb.last_wr + 64'($urandom_range(0, 16));
      send_item(2'($urandom_range(0, 3)), ts, 13'($urandom), 12'($urandom), rand_word());
   endtask

   task automatic drain();
      start = 1'b0;
      while (sb.pending_q.size() != 0) @(negedge clock);
   endtask

   initial begin
      repeat (LIMIT) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   initial begin
      logic [63:0] extreme [4];
      int k;
      int pick;
      int next_pause;
      extreme[0] = 64'h8000_7FFF_8000_7FFF;
      extreme[1] = 64'h7FFF_8000_7FFF_8000;
      extreme[2] = 64'hFFFF_0000_FFFF_0000;
      extreme[3] = 64'h0000_FFFF_0000_FFFF;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      send_item(tsrb_pkg::OP_SET_FIRST, 64'd0, 13'd1, 12'd0, 64'd0);
      send_item(tsrb_pkg::OP_SET_FIRST, 64'd2, 13'd1, 12'd0, 64'd0);
      send_item(tsrb_pkg::OP_SET_FIRST, 64'd9, 13'd1, 12'd0, 64'd0);
      for (k = 0; k < 4; k++)
         send_item(tsrb_pkg::OP_WRITE, WRAP_TS, 13'd4, 12'(k), extreme[k]);
      for (k = 0; k < 4; k++)
         send_item(tsrb_pkg::OP_READ, WRAP_TS, 13'd4, 12'(k), 64'd0);
      send_item(tsrb_pkg::OP_SET_FIRST, 64'd3, 13'd1, 12'd0, 64'd0);
      send_item(tsrb_pkg::OP_WRITE, 64'd1, 13'd1, 12'd0, rand_word());
      send_item(tsrb_pkg::OP_WRITE, 64'd2, 13'd0, 12'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(tsrb_pkg::OP_WRITE, 64'd3, 13'd4096, 12'd0, rand_word());
      send_item(tsrb_pkg::OP_WRITE, 64'd3, 13'd4096, 12'd1, rand_word());
      send_item(tsrb_pkg::OP_WRITE, 64'd3, 13'd2, 12'd5, rand_word());
      send_item(tsrb_pkg::OP_WRITE, 64'd3, 13'd4, 12'd2, rand_word());
      send_item(OP_UNUSED, 64'd3, 13'd4, 12'd0, rand_word());
      send_item(tsrb_pkg::OP_READ, 64'd1, 13'd1, 12'd0, 64'd0);
      send_item(tsrb_pkg::OP_READ, 64'd0, 13'd1, 12'd0, 64'd0);
      send_item(tsrb_pkg::OP_READ, 64'd2, 13'h1FFF, 12'd0, 64'd0);
      send_item(tsrb_pkg::OP_WRITE, 64'd3, 13'd4093, 12'd0, extreme[1]);
      send_item(tsrb_pkg::OP_WRITE, 64'd3, 13'd4093, 12'd4092, extreme[0]);
      send_item(tsrb_pkg::OP_READ, 64'd1, 13'd4095, 12'd0, 64'd0);
      send_item(tsrb_pkg::OP_READ, 64'd1, 13'd4095, 12'd4094, 64'd0);
      drain();

      next_pause = items_sent + PAUSE_STEP;
      while (items_sent < ITEMS) begin
         idle_on = (items_sent < ITEMS - QUIET_TAIL);
         if (items_sent >= next_pause) begin
            drain();
            next_pause += PAUSE_STEP;
         end
         pick = $urandom_range(0, 99);
         if (pick < 45) random_write();
         else if (pick < 88) random_read();
         else random_noise();
      end

      drain();
      repeat (SETTLE) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending_q.size() == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
